// ===== hw/rtl/infix_integer_expression_evaluator_top_defines.svh =====
// Assertion macros shared by the evaluator checker
`ifndef INFIX_INTEGER_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define INFIX_INTEGER_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define IIEE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iiee check failed");

// next-cycle implication, disabled in reset
`define IIEE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iiee check failed");

`endif

// ===== hw/rtl/iiee_pkg.sv =====
// Types and constants of the infix expression evaluator
package iiee_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned FIFO_DEPTH = 4;

    // operator token codes on the bus
    localparam logic [DATA_W-1:0] TOK_ADD = 32'd1;
    localparam logic [DATA_W-1:0] TOK_DIV = 32'd4;

    // internal operator codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DIV0  = 2'd1;
    localparam logic [1:0] STAT_BADOP = 2'd2;
    localparam logic [1:0] STAT_ENDOP = 2'd3;

    localparam logic [DATA_W-1:0] VAL_DIV0  = 32'h8000_0001;
    localparam logic [DATA_W-1:0] VAL_BADOP = 32'h8000_0002;

    // classified token as queued between front and back
    typedef struct packed {
        logic              is_op;
        logic              bad_op;
        logic [1:0]        op;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_entry;

endpackage

// ===== hw/rtl/iiee_fifo.sv =====
// Short register queue of classified tokens
module iiee_fifo #(
    parameter int unsigned P_DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  iiee_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output iiee_pkg::t_entry o_entry,
    output logic            o_empty
);
    import iiee_pkg::*;

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(P_DEPTH);

    t_entry           r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== hw/rtl/iiee_front.sv =====
// Token intake: operand/operator parity and operator decode
module iiee_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [iiee_pkg::DATA_W-1:0] i_token,
    input  logic                        i_last,
    input  logic                        i_full,
    output logic                        o_push,
    output iiee_pkg::t_entry            o_entry
);
    import iiee_pkg::*;

    logic       r_expect_op;
    logic       w_op_ok;
    logic [1:0] w_op_code;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        w_op_ok   = (i_token inside {[TOK_ADD:TOK_DIV]});
        w_op_code = i_token[1:0] - 2'd1;
    end

    always_comb begin
        o_entry.is_op  = r_expect_op;
        o_entry.bad_op = r_expect_op && !w_op_ok;
        o_entry.op     = w_op_code;
        o_entry.data   = i_token;
        o_entry.last   = i_last;
    end

    // parity restarts after the last word of an expression
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_op <= 1'b0;
        end else if (o_push) begin
            r_expect_op <= i_last ? 1'b0 : !r_expect_op;
        end
    end

endmodule

// ===== hw/rtl/iiee_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating
module iiee_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [iiee_pkg::DATA_W-1:0] i_dividend,
    input  logic [iiee_pkg::DATA_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [iiee_pkg::DATA_W-1:0] o_quotient
);
    import iiee_pkg::*;

    localparam int unsigned CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_div;
    logic              r_neg;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W+1:0] w_diff;

    assign w_shift    = {r_rem, r_quo[DATA_W-1]};
    assign w_diff     = {1'b0, w_shift} - {2'b00, r_div};
    assign o_done     = r_done;
    assign o_quotient = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend[DATA_W-1] ? (DATA_W'(0) - i_dividend) : i_dividend;
            r_div <= i_divisor[DATA_W-1] ? (DATA_W'(0) - i_divisor) : i_divisor;
            r_rem <= '0;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            if (!w_diff[DATA_W+1]) begin
                r_rem <= w_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== hw/rtl/iiee_back.sv =====
// Evaluation engine: sum/term state, error tracking, result register
module iiee_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  iiee_pkg::t_entry            i_entry,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [iiee_pkg::DATA_W-1:0] o_value,
    output logic [1:0]                  o_status
);
    import iiee_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [DATA_W-1:0] r_sum, n_sum;
    logic [DATA_W-1:0] r_term, n_term;
    logic              r_neg, n_neg;
    logic [1:0]        r_pend, n_pend;
    logic [1:0]        r_err, n_err;
    logic              r_was_op, n_was_op;
    logic              r_fin, n_fin;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    logic [1:0]        r_out_status, n_out_status;

    logic              w_div_start;
    logic              w_div_done;
    logic [DATA_W-1:0] w_quotient;
    logic [DATA_W-1:0] w_fold;
    logic [DATA_W-1:0] w_prod;
    logic [1:0]        w_stat;

    iiee_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_term),
        .i_divisor  (i_entry.data),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

    assign w_fold = r_neg ? (r_sum - r_term) : (r_sum + r_term);
    assign w_prod = r_term * i_entry.data;
    assign w_stat = (r_err == STAT_OK && r_was_op) ? STAT_ENDOP : r_err;

    always_comb begin
        n_state      = r_state;
        n_sum        = r_sum;
        n_term       = r_term;
        n_neg        = r_neg;
        n_pend       = r_pend;
        n_err        = r_err;
        n_was_op     = r_was_op;
        n_fin        = r_fin;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        w_div_start  = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_was_op = i_entry.is_op;
                    n_fin    = i_entry.last;
                    n_state  = i_entry.last ? S_EMIT : S_IDLE;
                    if (r_err == STAT_OK) begin
                        if (i_entry.is_op) begin
                            if (i_entry.bad_op) begin
                                n_err = STAT_BADOP;
                            end else begin
                                if (i_entry.op == OP_ADD || i_entry.op == OP_SUB) begin
                                    n_sum  = w_fold;
                                    n_term = '0;
                                    n_neg  = (i_entry.op == OP_SUB);
                                end
                                n_pend = i_entry.op;
                            end
                        end else begin
                            case (r_pend)
                                OP_MUL: begin
                                    n_term = w_prod;
                                end
                                OP_DIV: begin
                                    if (i_entry.data == '0) begin
                                        n_err = STAT_DIV0;
                                    end else begin
                                        w_div_start = 1'b1;
                                        n_state     = S_DIV;
                                    end
                                end
                                default: begin
                                    n_term = i_entry.data;
                                end
                            endcase
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_term  = w_quotient;
                    n_state = r_fin ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = w_stat;
                    case (w_stat)
                        STAT_DIV0:  n_out_value = VAL_DIV0;
                        STAT_BADOP: n_out_value = VAL_BADOP;
                        STAT_ENDOP: n_out_value = '0;
                        default:    n_out_value = w_fold;
                    endcase
                    n_sum    = '0;
                    n_term   = '0;
                    n_neg    = 1'b0;
                    n_pend   = OP_ADD;
                    n_err    = STAT_OK;
                    n_was_op = 1'b0;
                    n_fin    = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_term      <= '0;
            r_neg       <= 1'b0;
            r_pend      <= OP_ADD;
            r_err       <= STAT_OK;
            r_was_op    <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_term      <= n_term;
            r_neg       <= n_neg;
            r_pend      <= n_pend;
            r_err       <= n_err;
            r_was_op    <= n_was_op;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

endmodule

// ===== hw/rtl/infix_integer_expression_evaluator_top.sv =====
// Top level of the streaming infix integer expression evaluator
//
//  channel   dir  tdata                    tuser        tlast
//  s_axis    in   [31:0] token (signed)    -            last token
//  m_axis    out  [31:0] value (signed)    [1:0] status -
//
// Back end takes one operand or operator word per cycle in its idle state;
// an operand after a divide runs through the bit-serial divider (load,
// 32 steps, write), and a last word loads the result register.
// Reset is synchronous, active low; no clearing pass.
// Input stalls only when the P_FIFO_DEPTH-word token queue is full; the
// result register lets the queue keep filling while m_axis is stalled.
module infix_integer_expression_evaluator_top #(
    parameter int unsigned P_FIFO_DEPTH = iiee_pkg::FIFO_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [iiee_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] token
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [iiee_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] value
    output logic [1:0]                  m_axis_tuser   // [1:0] status
);
    import iiee_pkg::*;

    t_entry w_push_entry;
    t_entry w_pop_entry;
    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;

    iiee_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_token (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    iiee_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_empty (w_empty)
    );

    iiee_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_entry  (w_pop_entry),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_value  (m_axis_tdata),
        .o_status (m_axis_tuser)
    );

endmodule

// ===== hw/rtl/iiee_checker.sv =====
// Port-level checks of the evaluator and their bind
`include "infix_integer_expression_evaluator_top_defines.svh"

module iiee_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [iiee_pkg::DATA_W-1:0] m_axis_tdata,
    input logic [1:0]                  m_axis_tuser
);
    import iiee_pkg::*;

    logic              w_stall;
    logic [DATA_W+1:0] w_word;
    logic              w_div0;
    logic              w_badop;
    logic              w_endop;

    assign w_stall = m_axis_tvalid && !m_axis_tready;
    assign w_word  = {m_axis_tuser, m_axis_tdata};
    assign w_div0  = m_axis_tvalid && (m_axis_tuser == STAT_DIV0);
    assign w_badop = m_axis_tvalid && (m_axis_tuser == STAT_BADOP);
    assign w_endop = m_axis_tvalid && (m_axis_tuser == STAT_ENDOP);

    `IIEE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_stall, m_axis_tvalid && $stable(w_word))
    `IIEE_ASSERT_IMP(a_div0_value, i_clk, i_rst_n, w_div0, m_axis_tdata == VAL_DIV0)
    `IIEE_ASSERT_IMP(a_badop_value, i_clk, i_rst_n, w_badop, m_axis_tdata == VAL_BADOP)
    `IIEE_ASSERT_IMP(a_endop_value, i_clk, i_rst_n, w_endop, m_axis_tdata == '0)

endmodule

bind infix_integer_expression_evaluator_top iiee_checker u_iiee_checker (.*);
